/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define DTCRP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtcrp: same-cycle check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define DTCRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtcrp: next-cycle check failed");

`endif

/* hw/rtl/dtcrp_pkg.sv */
// Package: types and constants of the trouble code response parser.
`default_nettype none
package dtcrp_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_CODES_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int TOTAL_W = 5;

    // Configuration register indexes
    localparam logic REG_REQ_SERVICE = 1'b0;
    localparam logic REG_RESP_OFFSET = 1'b1;

    // Register reset values
    localparam logic [BYTE_W-1:0] REQ_SERVICE_RST = 8'h03;
    localparam logic [BYTE_W-1:0] RESP_OFFSET_RST = 8'h40;

    // Result kinds and summary status codes
    localparam logic KIND_CODE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_BAD   = 1'b1;

    // One queue entry: the results caused by one input byte
    typedef struct packed {
        logic               has_code;
        logic               has_summary;
        logic [BYTE_W-1:0]  high_byte;
        logic [BYTE_W-1:0]  low_byte;
        logic [TOTAL_W-1:0] total;
        logic               status;
    } entry_t;

endpackage
`default_nettype wire

/* hw/rtl/dtcrp_front.sv */
// Front end: holds the registers and response state, classifies each byte.
`default_nettype none
module dtcrp_front #(
    parameter int MAX_CODES = dtcrp_pkg::MAX_CODES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [dtcrp_pkg::BYTE_W-1:0]  cfg_data,
    input  wire logic                          in_valid,
    input  wire logic [dtcrp_pkg::BYTE_W-1:0]  payload_byte,
    input  wire logic                          final_byte,
    input  wire logic                          queue_full,
    output logic                               push,
    output dtcrp_pkg::entry_t                  entry
);

    localparam int CNT_W = $clog2(MAX_CODES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CODES);

    logic [dtcrp_pkg::BYTE_W-1:0] req_service_reg;
    logic [dtcrp_pkg::BYTE_W-1:0] resp_offset_reg;

    logic                         seen_reg, seen_next;
    logic                         bad_reg, bad_next;
    logic                         held_reg, held_next;
    logic [dtcrp_pkg::BYTE_W-1:0] held_byte_reg, held_byte_next;
    logic [CNT_W-1:0]             count_reg, count_next;

    logic                         accept;
    logic                         svc_match;
    logic                         code_fire;
    logic                         bad_now;
    logic [CNT_W-1:0]             count_now;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_service_reg <= dtcrp_pkg::REQ_SERVICE_RST;
            resp_offset_reg <= dtcrp_pkg::RESP_OFFSET_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dtcrp_pkg::REG_REQ_SERVICE: req_service_reg <= cfg_data;
                dtcrp_pkg::REG_RESP_OFFSET: resp_offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign accept    = in_valid && !queue_full;
    assign svc_match = ({1'b0, payload_byte} ==
                        ((dtcrp_pkg::BYTE_W+1)'(req_service_reg) +
                         (dtcrp_pkg::BYTE_W+1)'(resp_offset_reg)));

    // Advance the response state for an accepted byte
    always_comb
    begin
        seen_next      = seen_reg;
        bad_next       = bad_reg;
        held_next      = held_reg;
        held_byte_next = held_byte_reg;
        count_next     = count_reg;
        code_fire      = 1'b0;
        if (accept)
        begin
            if (!seen_reg)
            begin
                seen_next = 1'b1;
                bad_next  = !svc_match;
            end
            else if (!bad_reg)
            begin
                if (!held_reg)
                begin
                    held_byte_next = payload_byte;
                    held_next      = 1'b1;
                end
                else
                begin
                    held_next = 1'b0;
                    if ((held_byte_reg != '0 || payload_byte != '0) &&
                        count_reg < CNT_MAX)
                    begin
                        code_fire  = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
        end
        bad_now   = bad_next;
        count_now = count_next;
        // Clear the response state after the last byte
        if (accept && final_byte)
        begin
            seen_next      = 1'b0;
            bad_next       = 1'b0;
            held_next      = 1'b0;
            held_byte_next = '0;
            count_next     = '0;
        end
    end

    // Build the queue entry
    always_comb
    begin
        push              = accept && (code_fire || final_byte);
        entry.has_code    = code_fire;
        entry.has_summary = final_byte;
        entry.high_byte   = held_byte_reg;
        entry.low_byte    = payload_byte;
        entry.total       = bad_now ? '0 : dtcrp_pkg::TOTAL_W'(count_now);
        entry.status      = bad_now ? dtcrp_pkg::STATUS_BAD : dtcrp_pkg::STATUS_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            bad_reg       <= 1'b0;
            held_reg      <= 1'b0;
            held_byte_reg <= '0;
            count_reg     <= '0;
        end
        else
        begin
            seen_reg      <= seen_next;
            bad_reg       <= bad_next;
            held_reg      <= held_next;
            held_byte_reg <= held_byte_next;
            count_reg     <= count_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/dtcrp_queue.sv */
// Short entry queue between the front end and the result stage.
`default_nettype none
module dtcrp_queue #(
    parameter int DEPTH = dtcrp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire dtcrp_pkg::entry_t push_data,
    input  wire logic              pop,
    output dtcrp_pkg::entry_t      head,
    output logic                   empty,
    output logic                   full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dtcrp_pkg::entry_t slots_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign head    = slots_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

/* hw/rtl/dtcrp_back.sv */
// Result stage: expands queue entries into code and summary results.
`default_nettype none
module dtcrp_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dtcrp_pkg::entry_t             head,
    input  wire logic                          head_empty,
    output logic                               pop,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               item_kind,
    output logic [1:0]                         category,
    output logic [1:0]                         first_digit,
    output logic [3:0]                         second_digit,
    output logic [3:0]                         third_digit,
    output logic [3:0]                         fourth_digit,
    output logic [15:0]                        raw_code,
    output logic [dtcrp_pkg::TOTAL_W-1:0]      code_total,
    output logic                               result_status,
    output logic                               end_of_run
);

    logic        valid_reg, valid_next;
    logic        phase_reg, phase_next;
    logic        load;
    logic        head_valid;
    logic        emit_sum;

    logic        kind_reg;
    logic [7:0]  hi_reg;
    logic [7:0]  lo_reg;
    logic [dtcrp_pkg::TOTAL_W-1:0] total_reg;
    logic        status_reg;
    logic        eor_reg;

    assign head_valid = !head_empty;
    assign load       = !valid_reg || !out_stall;
    assign emit_sum   = head.has_summary && (phase_reg || !head.has_code);
    assign pop        = load && head_valid && (emit_sum || !head.has_summary);

    // Step through the results of the head entry
    always_comb
    begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        if (load)
        begin
            valid_next = head_valid;
            if (head_valid)
                phase_next = !emit_sum && head.has_code && head.has_summary;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    // Load the output register on a free slot
    always_ff @(posedge clk)
    begin
        if (load && head_valid)
        begin
            kind_reg   <= emit_sum ? dtcrp_pkg::KIND_SUMMARY : dtcrp_pkg::KIND_CODE;
            hi_reg     <= emit_sum ? '0 : head.high_byte;
            lo_reg     <= emit_sum ? '0 : head.low_byte;
            total_reg  <= head.total;
            status_reg <= emit_sum ? head.status : dtcrp_pkg::STATUS_OK;
            eor_reg    <= emit_sum || !head.has_summary;
        end
    end

    assign out_valid     = valid_reg;
    assign item_kind     = kind_reg;
    assign category      = hi_reg[7:6];
    assign first_digit   = hi_reg[5:4];
    assign second_digit  = hi_reg[3:0];
    assign third_digit   = lo_reg[7:4];
    assign fourth_digit  = lo_reg[3:0];
    assign raw_code      = {hi_reg, lo_reg};
    assign code_total    = total_reg;
    assign result_status = status_reg;
    assign end_of_run    = eor_reg;

endmodule
`default_nettype wire

/* hw/rtl/dtc_response_parser.sv */
// Top level of the trouble code response parser.
//
//   channel   direction  handshake              payload
//   cfg       in         cfg_we                 cfg_index, cfg_data
//   in        in         in_valid / in_stall    payload_byte, final_byte
//   out       out        out_valid / out_stall  item_kind ... end_of_run
//
// One byte is taken per cycle while in_stall is low; a code result goes
// from the byte that completes it through the queue write, then the output
// register, plus any queue wait. A last byte that also completes a code
// gives two results, the code and then the summary, one after the other
// from the single output register. in_stall rises only when the
// QUEUE_DEPTH-entry queue is full. Reset loads the registers with service 3
// and offset 64 and clears the response state; no clearing pass is needed.
`default_nettype none
module dtc_response_parser #(
    parameter int MAX_CODES   = dtcrp_pkg::MAX_CODES_DEF,
    parameter int QUEUE_DEPTH = dtcrp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [dtcrp_pkg::BYTE_W-1:0]  cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [dtcrp_pkg::BYTE_W-1:0]  payload_byte,
    input  wire logic                          final_byte,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               item_kind,
    output logic [1:0]                         category,
    output logic [1:0]                         first_digit,
    output logic [3:0]                         second_digit,
    output logic [3:0]                         third_digit,
    output logic [3:0]                         fourth_digit,
    output logic [15:0]                        raw_code,
    output logic [dtcrp_pkg::TOTAL_W-1:0]      code_total,
    output logic                               result_status,
    output logic                               end_of_run
);

    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;
    dtcrp_pkg::entry_t push_entry;
    dtcrp_pkg::entry_t head_entry;

    assign in_stall = q_full;

    dtcrp_front #(
        .MAX_CODES (MAX_CODES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .payload_byte (payload_byte),
        .final_byte   (final_byte),
        .queue_full   (q_full),
        .push         (push),
        .entry        (push_entry)
    );

    dtcrp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_entry),
        .pop       (pop),
        .head      (head_entry),
        .empty     (q_empty),
        .full      (q_full)
    );

    dtcrp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head_entry),
        .head_empty    (q_empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .item_kind     (item_kind),
        .category      (category),
        .first_digit   (first_digit),
        .second_digit  (second_digit),
        .third_digit   (third_digit),
        .fourth_digit  (fourth_digit),
        .raw_code      (raw_code),
        .code_total    (code_total),
        .result_status (result_status),
        .end_of_run    (end_of_run)
    );

endmodule
`default_nettype wire

/* hw/rtl/dtcrp_checker.sv */
// Port-level checker for the response parser, with its bind.
`default_nettype none
`include "assert_macros.svh"
module dtcrp_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic                          item_kind,
    input  wire logic [1:0]                    category,
    input  wire logic [15:0]                   raw_code,
    input  wire logic [dtcrp_pkg::TOTAL_W-1:0] code_total,
    input  wire logic                          result_status,
    input  wire logic                          end_of_run
);

    // Hold a stalled result
    `DTCRP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(raw_code) && $stable(item_kind) && $stable(code_total))

    // A summary carries no code and always ends the run
    `DTCRP_ASSERT_NOW(a_sum_clean, clk, rst_n, out_valid && item_kind == dtcrp_pkg::KIND_SUMMARY, raw_code == '0 && category == '0 && end_of_run)

    // A code result is ok-status and counted
    `DTCRP_ASSERT_NOW(a_code_counted, clk, rst_n, out_valid && item_kind == dtcrp_pkg::KIND_CODE, result_status == dtcrp_pkg::STATUS_OK && raw_code != '0)

    // An invalid response reports no codes
    `DTCRP_ASSERT_NOW(a_bad_zero, clk, rst_n, out_valid && result_status == dtcrp_pkg::STATUS_BAD, code_total == '0)

endmodule

bind dtc_response_parser dtcrp_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .item_kind     (item_kind),
    .category      (category),
    .raw_code      (raw_code),
    .code_total    (code_total),
    .result_status (result_status),
    .end_of_run    (end_of_run)
);
`default_nettype wire
